/* hdl/assert_macros.svh */
// Assertion macros used by the verification file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mlgm_pkg.sv */
`timescale 1ns / 1ps

package mlgm_pkg;

  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned SLOT_W    = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NOTE_ON      = 2'd0,
    ACT_NOTE_OFF     = 2'd1,
    ACT_LEARN_TOGGLE = 2'd2
  } action_e;

endpackage

/* hdl/midi_learn_gate_mapper_unit.sv */
`timescale 1ns / 1ps

// MIDI learn note-to-gate mapper. Each slot remembers one learned MIDI channel and note
// and drives one gate. Outside learn mode, a note on sets the gate of every matching slot
// and a note off clears it; in learn mode each note on is stored in the next slot, and a
// learn toggle starts learning at slot 0 or stops it. Every accepted transaction returns
// exactly one result showing the state after the event: the gate mask with the slot being
// learned forced low, an identical LED mask, the learning flag and the learned slot
// (zero when not learning). The block takes one event per clock cycle while the result
// side does not stall; an accepted event is captured in the input register, and the
// per-slot channel and note compare runs between it and the result register. A stall on
// the result side holds the result register and then backs up into the input register.
module midi_learn_gate_mapper_unit
  import mlgm_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ACTION_W-1:0]  action_i,
  input  logic [CHANNEL_W-1:0] midi_channel_i,
  input  logic [NOTE_W-1:0]    note_number_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [MASK_W-1:0]    gate_mask_o,
  output logic [MASK_W-1:0]    led_on_mask_o,
  output logic                 learning_o,
  output logic [SLOT_W-1:0]    learn_slot_o
);

  localparam int unsigned PosW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(SLOT_COUNT - 1);

  // Input register
  logic                 in_valid_q;
  action_e              action_q;
  logic [CHANNEL_W-1:0] chan_q;
  logic [NOTE_W-1:0]    note_q;

  // Slot table and learn state
  logic                 slot_valid_q [SLOT_COUNT];
  logic [CHANNEL_W-1:0] slot_chan_q  [SLOT_COUNT];
  logic [NOTE_W-1:0]    slot_note_q  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] gate_q, gate_d;
  logic                 learn_q, learn_d;
  logic [PosW-1:0]      pos_q, pos_d;

  // Result register
  logic                 out_valid_q;
  logic [MASK_W-1:0]    mask_q, mask_d;
  logic                 learning_q;
  logic [SLOT_W-1:0]    learn_slot_q, learn_slot_d;

  logic                  advance;
  logic                  fire;
  logic                  accept;
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] load_slot;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_e'(action_i);
      chan_q   <= midi_channel_i;
      note_q   <= note_number_i;
    end
  end

  // A slot that was never learned holds no valid entry and therefore never matches.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i] = slot_valid_q[i] && (slot_chan_q[i] == chan_q) && (slot_note_q[i] == note_q);
    end
  end

  always_comb begin
    learn_d   = learn_q;
    pos_d     = pos_q;
    gate_d    = gate_q;
    load_slot = '0;
    case (action_q)
      ACT_NOTE_ON: begin
        if (!learn_q) begin
          gate_d = gate_q | hit;
        end else begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            load_slot[i] = (pos_q == PosW'(i));
          end
          if (pos_q == LastPos) begin
            learn_d = 1'b0;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + PosW'(1);
          end
        end
      end
      ACT_NOTE_OFF: begin
        if (!learn_q) begin
          gate_d = gate_q & ~hit;
        end
      end
      ACT_LEARN_TOGGLE: begin
        learn_d = !learn_q;
        pos_d   = '0;
      end
      default: begin
      end
    endcase
  end

  // Only the first eight slots are visible; the slot being learned shows its gate low.
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < SLOT_COUNT) begin : g_slot
      assign mask_d[g] = gate_d[g] && !(learn_d && (pos_d == PosW'(g)));
    end else begin : g_none
      assign mask_d[g] = 1'b0;
    end
  end

  assign learn_slot_d = learn_d ? SLOT_W'(pos_d) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q  <= '0;
      learn_q <= 1'b0;
      pos_q   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_valid_q[i] <= 1'b0;
      end
    end else if (fire) begin
      gate_q  <= gate_d;
      learn_q <= learn_d;
      pos_q   <= pos_d;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (load_slot[i]) begin
          slot_valid_q[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (fire && load_slot[i]) begin
        slot_chan_q[i] <= chan_q;
        slot_note_q[i] <= note_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mask_q       <= mask_d;
      learning_q   <= learn_d;
      learn_slot_q <= learn_slot_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign gate_mask_o   = mask_q;
  assign led_on_mask_o = mask_q;
  assign learning_o    = learning_q;
  assign learn_slot_o  = learn_slot_q;

endmodule

/* hdl/mlgm_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlgm_checker
  import mlgm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [MASK_W-1:0]    gate_mask_o,
  input logic [MASK_W-1:0]    led_on_mask_o,
  input logic                 learning_o,
  input logic [SLOT_W-1:0]    learn_slot_o
);

  logic                       idle_out;
  logic                       learn_out;
  logic                       out_held;
  logic                       in_held;
  logic [MASK_W+SLOT_W:0]     result_word;

  assign idle_out    = out_valid_o && !learning_o;
  assign learn_out   = out_valid_o && learning_o;
  assign out_held    = out_valid_o && out_stall_i;
  assign in_held     = in_valid_i && in_stall_o;
  assign result_word = {gate_mask_o, learning_o, learn_slot_o};

  // Both masks come from the same gate state.
  `ASSERT_IMPLY(a_masks_equal, clk_i, rst_ni, out_valid_o, gate_mask_o == led_on_mask_o, "masks differ")

  // The reported slot is meaningful only in learn mode and is zero otherwise.
  `ASSERT_IMPLY(a_slot_idle_zero, clk_i, rst_ni, idle_out, learn_slot_o == '0, "slot set when idle")

  // The gate of the slot being learned is always shown low.
  `ASSERT_IMPLY(a_learn_gate_low, clk_i, rst_ni, learn_out, !gate_mask_o[learn_slot_o], "learned gate high")

  // A stalled result stays valid and unchanged.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(result_word), "result changed")

  // A stalled input transaction stays offered.
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_held, in_valid_i, "stalled transaction withdrawn")

endmodule

bind midi_learn_gate_mapper_unit mlgm_checker u_mlgm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .gate_mask_o  (gate_mask_o),
  .led_on_mask_o(led_on_mask_o),
  .learning_o   (learning_o),
  .learn_slot_o (learn_slot_o)
);
